// ===== hdl/kefq_pkg.sv =====
// ----------------------------------------------------------------------------
// kefq_pkg
// shared types, sizes and codes of the key edge filter queue
// ----------------------------------------------------------------------------
package kefq_pkg;

    // event queue depth, range 2 to 1024
    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam int KEY_W     = 8;
    localparam int KEY_COUNT = 256;
    localparam int SCAN_W    = 9;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [1:0]       opcode_t;

    localparam key_t KEY_NONE = 8'h00;
    localparam key_t KEY_MAX  = 8'hFF;

    // request opcodes
    localparam opcode_t OP_KEY   = 2'd0;
    localparam opcode_t OP_FOCUS = 2'd1;
    localparam opcode_t OP_POP   = 2'd2;

    // one queued event
    typedef struct packed {
        logic pressed;
        key_t key;
    } evt_entry_t;

    // circular increment of a queue pointer
    function automatic ptr_t next_ptr(input ptr_t p);
        if (p == ptr_t'(QUEUE_DEPTH - 1))
        begin
            next_ptr = '0;
        end
        else
        begin
            next_ptr = p + ptr_t'(1);
        end
    endfunction

endpackage

// ===== hdl/kefq_if.sv =====
// ----------------------------------------------------------------------------
// kefq_req_if / kefq_evt_if
// valid/ready channels of the key edge filter queue
// ----------------------------------------------------------------------------
interface kefq_req_if import kefq_pkg::*; ();
    logic    valid;
    logic    ready;
    opcode_t opcode;
    logic    pressed;
    key_t    key_code;

    modport source (output valid, output opcode, output pressed, output key_code,
                    input ready);
    modport sink   (input valid, input opcode, input pressed, input key_code,
                    output ready);
endinterface

interface kefq_evt_if import kefq_pkg::*; ();
    logic valid;
    logic ready;
    logic event_valid;
    logic out_pressed;
    key_t out_key;

    modport source (output valid, output event_valid, output out_pressed,
                    output out_key, input ready);
    modport sink   (input valid, input event_valid, input out_pressed,
                    input out_key, output ready);
endinterface

// ===== hdl/key_edge_filter_queue.sv =====
// ----------------------------------------------------------------------------
// key_edge_filter_queue
// held-key filter in front of a circular keyboard event queue
// ----------------------------------------------------------------------------
// usage
//   req (sink): one request per handshake, opcode key edge, focus lost or pop.
//     a key edge with code 0, a press of a held key or a release of a free
//     key changes nothing; a real edge queues one event.
//     focus lost releases every held key in ascending code order.
//     a pop returns one response on evt; other requests return none.
//   evt (source): event_valid, out_pressed, out_key; event_valid 0 with zero
//     payload when the queue was empty.
// sequence
//   key edge: held map read, then write back and enqueue.
//   pop: event store read, then the output register load, which waits out any stall on evt.
//   focus lost: codes 0 to 255, one held map entry read per cycle.
//   key edge and focus lost are set by the one read and one write port of the held map.
// reset
//   pointers clear at once; the held map is swept to zero, one entry a cycle,
//   codes 0 to 255, while req.ready stays low.
// stall
//   a waiting response sits in the output register; requests are still taken,
//   a following pop holds in its output load step until the register frees up.
// ----------------------------------------------------------------------------
module key_edge_filter_queue
    import kefq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    kefq_req_if.sink          req,
    kefq_evt_if.source        evt
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_KEY   = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_POP   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // held map memory and its ports
    logic       held_mem [KEY_COUNT];
    logic       held_q;
    logic       held_re;
    key_t       held_ra;
    logic       held_we;
    key_t       held_wa;
    logic       held_wd;

    // event store memory and its ports
    evt_entry_t store_mem [QUEUE_DEPTH];
    evt_entry_t store_q;
    logic       store_re;
    logic       enq_en;
    evt_entry_t enq_data;

    ptr_t       wr_reg, wr_next;
    ptr_t       rd_reg, rd_next;
    ptr_t       wr_adv;

    key_t             clr_cnt_reg, clr_cnt_next;
    logic [SCAN_W-1:0] scan_cnt_reg, scan_cnt_next;
    key_t             chk_key_reg, chk_key_next;
    logic             cmd_pressed_reg, cmd_pressed_next;
    key_t             cmd_key_reg, cmd_key_next;
    logic             empty_reg, empty_next;

    logic       out_valid_reg, out_valid_next;
    evt_entry_t out_data_reg, out_data_next;
    logic       out_event_reg, out_event_next;
    logic       out_load;
    logic       req_fire;

    assign req.ready       = (state_reg == ST_IDLE);
    assign req_fire        = req.valid && req.ready;
    assign evt.valid       = out_valid_reg;
    assign evt.event_valid = out_event_reg;
    assign evt.out_pressed = out_data_reg.pressed;
    assign evt.out_key     = out_data_reg.key;

    // held map: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (held_we)
        begin
            held_mem[held_wa] <= held_wd;
        end
        if (held_re)
        begin
            held_q <= held_mem[held_ra];
        end
    end

    // event store: write at the write pointer, registered read at the read pointer
    always_ff @(posedge clk)
    begin
        if (enq_en)
        begin
            store_mem[wr_reg] <= enq_data;
        end
        if (store_re)
        begin
            store_q <= store_mem[rd_reg];
        end
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        scan_cnt_next    = scan_cnt_reg;
        chk_key_next     = chk_key_reg;
        cmd_pressed_next = cmd_pressed_reg;
        cmd_key_next     = cmd_key_reg;
        empty_next       = empty_reg;
        held_re          = 1'b0;
        held_ra          = req.key_code;
        held_we          = 1'b0;
        held_wa          = cmd_key_reg;
        held_wd          = 1'b0;
        enq_en           = 1'b0;
        enq_data         = '{pressed: 1'b0, key: chk_key_reg};
        store_re         = 1'b0;
        out_load         = 1'b0;
        rd_next          = rd_reg;
        wr_next          = wr_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                // sweep the held map to zero after reset
                held_we      = 1'b1;
                held_wa      = clr_cnt_reg;
                held_wd      = 1'b0;
                clr_cnt_next = clr_cnt_reg + key_t'(1);
                if (clr_cnt_reg == KEY_MAX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.opcode)
                        OP_KEY:
                        begin
                            cmd_pressed_next = req.pressed;
                            cmd_key_next     = req.key_code;
                            if (req.key_code != KEY_NONE)
                            begin
                                held_re    = 1'b1;
                                held_ra    = req.key_code;
                                state_next = ST_KEY;
                            end
                        end
                        OP_FOCUS:
                        begin
                            // first read at code 0, then one per cycle
                            held_re       = 1'b1;
                            held_ra       = KEY_NONE;
                            chk_key_next  = KEY_NONE;
                            scan_cnt_next = SCAN_W'(1);
                            state_next    = ST_SCAN;
                        end
                        OP_POP:
                        begin
                            empty_next = (rd_reg == wr_reg);
                            if (rd_reg != wr_reg)
                            begin
                                store_re = 1'b1;
                                rd_next  = next_ptr(rd_reg);
                            end
                            state_next = ST_POP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_KEY:
            begin
                // real edge only when the direction differs from the held bit
                if (cmd_pressed_reg != held_q)
                begin
                    held_we  = 1'b1;
                    held_wa  = cmd_key_reg;
                    held_wd  = cmd_pressed_reg;
                    enq_en   = 1'b1;
                    enq_data = '{pressed: cmd_pressed_reg, key: cmd_key_reg};
                end
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                // check the code read last cycle, issue the read of the next one
                if (held_q)
                begin
                    held_we  = 1'b1;
                    held_wa  = chk_key_reg;
                    held_wd  = 1'b0;
                    enq_en   = 1'b1;
                    enq_data = '{pressed: 1'b0, key: chk_key_reg};
                end
                if (scan_cnt_reg == SCAN_W'(KEY_COUNT))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    held_re       = 1'b1;
                    held_ra       = scan_cnt_reg[KEY_W-1:0];
                    chk_key_next  = scan_cnt_reg[KEY_W-1:0];
                    scan_cnt_next = scan_cnt_reg + SCAN_W'(1);
                end
            end
            ST_POP:
            begin
                // wait for a free output register
                if (!out_valid_reg || evt.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // enqueue: a full queue drops its oldest entry
        wr_adv = next_ptr(wr_reg);
        if (enq_en)
        begin
            wr_next = wr_adv;
            if (wr_adv == rd_reg)
            begin
                rd_next = next_ptr(rd_reg);
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_event_next = out_event_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_event_next = !empty_reg;
            out_data_next  = empty_reg ? evt_entry_t'{pressed: 1'b0, key: KEY_NONE}
                                       : store_q;
        end
        else if (evt.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            scan_cnt_reg  <= '0;
            wr_reg        <= '0;
            rd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            scan_cnt_reg  <= scan_cnt_next;
            wr_reg        <= wr_next;
            rd_reg        <= rd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        chk_key_reg     <= chk_key_next;
        cmd_pressed_reg <= cmd_pressed_next;
        cmd_key_reg     <= cmd_key_next;
        empty_reg       <= empty_next;
        out_data_reg    <= out_data_next;
        out_event_reg   <= out_event_next;
    end

    // after an enqueue the queue is never seen as empty
    a_enq_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        enq_en |=> (wr_reg != rd_reg))
        else $error("queue empty right after enqueue");

    // pointers stay inside the queue
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(wr_reg) < QUEUE_DEPTH) && (int'(rd_reg) < QUEUE_DEPTH))
        else $error("queue pointer out of range");

    // code 0 is never marked as held
    a_no_hold_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (held_we && held_wd) |-> (held_wa != KEY_NONE))
        else $error("key code 0 marked held");

    // an empty pop answers with a zero payload
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (evt.valid && !evt.event_valid) |-> (!evt.out_pressed && evt.out_key == KEY_NONE))
        else $error("empty pop with nonzero payload");

    // no enqueue while a pop read is in flight
    a_pop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        store_re |=> !enq_en && (state_reg == ST_POP))
        else $error("enqueue during pop");

endmodule

// ===== bench/kefq_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kefq_event_checker
// watches both channels, tracks held keys and the event ring, and compares
// every pop response with the predicted event
// ----------------------------------------------------------------------------
module kefq_event_checker
    import kefq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    kefq_req_if  req,
    kefq_evt_if  evt,
    output int   fail_count,
    output int   pending_pops
);

    typedef struct packed {
        logic event_valid;
        logic pressed;
        key_t key;
    } pop_result_t;

    logic        held_keys [KEY_COUNT];
    evt_entry_t  event_ring [QUEUE_DEPTH];
    int          wr_idx;
    int          rd_idx;
    pop_result_t pop_results [$];

    function automatic int ring_next(input int i);
        return (i + 1 == QUEUE_DEPTH) ? 0 : i + 1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] event check: %s", $time, msg);
        fail_count++;
    endtask

    // a full ring drops its oldest entry
    task automatic log_event(input logic p, input key_t k);
        event_ring[wr_idx] = '{pressed: p, key: k};
        wr_idx = ring_next(wr_idx);
        if (wr_idx == rd_idx)
        begin
            rd_idx = ring_next(rd_idx);
        end
    endtask

    task automatic predict_request(input opcode_t op, input logic p, input key_t k);
        pop_result_t r;
        r = '0;
        case (op)
            OP_KEY:
            begin
                if (k != KEY_NONE && held_keys[k] != p)
                begin
                    held_keys[k] = p;
                    log_event(p, k);
                end
            end
            OP_FOCUS:
            begin
                for (int i = 0; i < KEY_COUNT; i++)
                begin
                    if (held_keys[i])
                    begin
                        held_keys[i] = 1'b0;
                        log_event(1'b0, key_t'(i));
                    end
                end
            end
            OP_POP:
            begin
                if (rd_idx != wr_idx)
                begin
                    r.event_valid = 1'b1;
                    r.pressed     = event_ring[rd_idx].pressed;
                    r.key         = event_ring[rd_idx].key;
                    rd_idx        = ring_next(rd_idx);
                end
                pop_results.push_back(r);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_response(input logic ev, input logic p, input key_t k);
        pop_result_t want;
        if (pop_results.size() == 0)
        begin
            report_mismatch($sformatf("response with no pop waiting (%0b %0b %02h)",
                                      ev, p, k));
        end
        else
        begin
            want = pop_results.pop_front();
            if (ev !== want.event_valid)
            begin
                report_mismatch($sformatf("event_valid %0b, want %0b", ev,
                                          want.event_valid));
            end
            if (p !== want.pressed)
            begin
                report_mismatch($sformatf("out_pressed %0b, want %0b", p, want.pressed));
            end
            if (k !== want.key)
            begin
                report_mismatch($sformatf("out_key %02h, want %02h", k, want.key));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_COUNT; i++)
            begin
                held_keys[i] = 1'b0;
            end
            wr_idx = 0;
            rd_idx = 0;
            pop_results.delete();
            pending_pops = 0;
        end
        else
        begin
            if (evt.valid && evt.ready)
            begin
                check_response(evt.event_valid, evt.out_pressed, evt.out_key);
            end
            if (req.valid && req.ready)
            begin
                predict_request(req.opcode, req.pressed, req.key_code);
            end
            pending_pops = pop_results.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives key edges, focus-lost and pop requests into the key edge filter
// queue with random gaps on both channels, and gives the verdict from the
// event checker's failure count
// ----------------------------------------------------------------------------
module testbench;
    import kefq_pkg::*;

    // the one opcode the block leaves unused
    localparam opcode_t OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1600;
    // long receiver hold-off, in cycles, to fill the block and stall req
    localparam int LONG_HOLD    = 400;
    // cycles with no handshake on either channel before giving up
    localparam int IDLE_LIMIT   = 5000;
    // settle time after the last response, covers a full focus-lost scan
    localparam int DRAIN_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n;

    kefq_req_if req_bus ();
    kefq_evt_if evt_bus ();

    int fail_count;
    int pending_pops;

    // steady: no gaps on either side for the current stretch
    bit steady = 1'b0;
    // set by the stimulus, taken and cleared by the receiver
    bit hold_request = 1'b0;
    int counted_items = 0;
    int idle_cycles = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    key_edge_filter_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .evt   (evt_bus)
    );

    kefq_event_checker event_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_bus),
        .evt          (evt_bus),
        .fail_count   (fail_count),
        .pending_pops (pending_pops)
    );

    // watchdog: the run must keep moving on at least one channel
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((req_bus.valid && req_bus.ready) || (evt_bus.valid && evt_bus.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // one request: random gap, then hold valid until the block takes it
    task automatic send_request(input opcode_t op, input logic p, input key_t k);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            @(negedge clk);
            req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_bus.valid    <= 1'b1;
        req_bus.opcode   <= op;
        req_bus.pressed  <= p;
        req_bus.key_code <= k;
        @(posedge clk);
        while (!req_bus.ready)
        begin
            @(posedge clk);
        end
        // ignored requests do not count toward the random total
        if (op != OP_UNUSED && !(op == OP_KEY && k == KEY_NONE))
        begin
            counted_items++;
        end
    endtask

    // receiver: random gap before each response, one long hold-off on request
    initial
    begin
        int gap;
        evt_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                gap = LONG_HOLD;
            end
            else
            begin
                gap = steady ? 0 : $urandom_range(0, 14);
            end
            if (gap > 0)
            begin
                @(negedge clk);
                evt_bus.ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            evt_bus.ready <= 1'b1;
            @(posedge clk);
            while (!evt_bus.valid)
            begin
                @(posedge clk);
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int    seg;
        int    r;
        int    n;
        bit    hold_done;
        key_t  base;
        key_t  kk;

        hold_done        = 1'b0;
        rst_n            = 1'b0;
        req_bus.valid    = 1'b0;
        req_bus.opcode   = OP_KEY;
        req_bus.pressed  = 1'b0;
        req_bus.key_code = KEY_NONE;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // directed part
        // pop on an empty queue gives event_valid 0 with zero payload
        send_request(OP_POP, 1'b1, KEY_MAX);
        // key code 0 is ignored either way
        send_request(OP_KEY, 1'b1, KEY_NONE);
        send_request(OP_KEY, 1'b0, KEY_NONE);
        send_request(OP_KEY, 1'b1, 8'h01);
        // press of a held key is dropped
        send_request(OP_KEY, 1'b1, 8'h01);
        send_request(OP_KEY, 1'b1, KEY_MAX);
        send_request(OP_KEY, 1'b0, KEY_MAX);
        // release of a free key is dropped
        send_request(OP_KEY, 1'b0, 8'h07);
        // unused opcode changes nothing
        send_request(OP_UNUSED, 1'b1, 8'hAA);
        // focus lost ignores its pressed and key fields, releases key 1
        send_request(OP_FOCUS, 1'b1, 8'h55);
        send_request(OP_POP, 1'b0, 8'h00);
        send_request(OP_POP, 1'b1, 8'hFF);
        send_request(OP_POP, 1'b0, 8'h5A);
        send_request(OP_POP, 1'b1, 8'hA5);
        send_request(OP_POP, 1'b0, 8'h00);
        // focus lost with nothing held queues nothing
        send_request(OP_FOCUS, 1'b0, 8'h00);
        send_request(OP_KEY, 1'b1, 8'h80);
        send_request(OP_KEY, 1'b1, 8'h7F);
        send_request(OP_FOCUS, 1'b0, KEY_MAX);
        send_request(OP_POP, 1'b1, 8'h00);
        send_request(OP_POP, 1'b1, 8'h00);
        send_request(OP_POP, 1'b1, 8'h00);
        send_request(OP_POP, 1'b0, 8'h00);
        send_request(OP_POP, 1'b0, 8'h00);
        send_request(OP_POP, 1'b0, 8'h00);

        counted_items = 0;

        // random part, in stretches of different shapes
        while (counted_items < RANDOM_ITEMS)
        begin
            seg    = $urandom_range(0, 99);
            steady = ($urandom_range(0, 3) == 0);
            if (!hold_done && counted_items >= 500)
            begin
                // receiver holds off while pops keep coming: the output
                // register fills, a second pop parks and req stalls
                hold_done    = 1'b1;
                steady       = 1'b1;
                hold_request = 1'b1;
                repeat (24) send_request(OP_POP, 1'($urandom), key_t'($urandom));
            end
            else if (seg < 60)
            begin
                // mixed typing over a small key pool, with some noise
                repeat (20)
                begin
                    r = $urandom_range(0, 99);
                    if ($urandom_range(0, 9) == 0)
                    begin
                        kk = key_t'($urandom_range(0, 255));
                    end
                    else
                    begin
                        kk = key_t'($urandom_range(1, 12));
                    end
                    if (r < 55)
                    begin
                        send_request(OP_KEY, 1'($urandom), kk);
                    end
                    else if (r < 90)
                    begin
                        send_request(OP_POP, 1'($urandom), key_t'($urandom));
                    end
                    else if (r < 93)
                    begin
                        send_request(OP_FOCUS, 1'($urandom), key_t'($urandom));
                    end
                    else if (r < 97)
                    begin
                        send_request(OP_UNUSED, 1'($urandom), key_t'($urandom));
                    end
                    else
                    begin
                        send_request(OP_KEY, 1'($urandom), KEY_NONE);
                    end
                end
            end
            else if (seg < 75)
            begin
                // press a run of keys, then release them; long runs wrap the ring
                // and drop the oldest events
                n    = $urandom_range(8, 40);
                base = key_t'($urandom);
                for (int i = 0; i < n; i++)
                begin
                    kk = base + key_t'(i);
                    send_request(OP_KEY, 1'b1, (kk == KEY_NONE) ? 8'h01 : kk);
                end
                for (int i = 0; i < n; i++)
                begin
                    kk = base + key_t'(i);
                    send_request(OP_KEY, 1'b0, (kk == KEY_NONE) ? 8'h01 : kk);
                end
            end
            else if (seg < 85)
            begin
                // many held keys, then focus lost floods the ring
                n    = $urandom_range(40, 90);
                base = key_t'($urandom);
                for (int i = 0; i < n; i++)
                begin
                    kk = base + key_t'(i);
                    send_request(OP_KEY, 1'b1, (kk == KEY_NONE) ? KEY_MAX : kk);
                end
                send_request(OP_FOCUS, 1'($urandom), key_t'($urandom));
            end
            else
            begin
                // drain the ring and run into empty pops
                n = $urandom_range(10, 70);
                repeat (n) send_request(OP_POP, 1'($urandom), key_t'($urandom));
            end
        end

        @(negedge clk);
        req_bus.valid <= 1'b0;
        steady = 1'b0;

        wait (pending_pops == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_pops == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/kefq_pkg.sv
hdl/kefq_if.sv
hdl/key_edge_filter_queue.sv
bench/kefq_event_checker.sv
bench/testbench.sv
